// File: hw/rtl/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

  // Default number of fraction bits of the life quotient
  localparam int unsigned LifeFracBitsDef = 8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CRIT_VOLT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_LEVEL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DONE_LEVEL = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [15:0] CRIT_VOLT_RST = 16'd3400;
  localparam logic [6:0] LOW_LEVEL_RST = 7'd20;
  localparam logic [6:0] DONE_LEVEL_RST = 7'd1;

  // Stream widths
  localparam int unsigned InTdataW = 72;
  localparam int unsigned OutTdataW = 32;

  localparam int unsigned LifeW = 24;
  localparam logic [LifeW-1:0] LIFE_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } bsm_state_e;

  typedef struct packed {
    logic        start;
    logic [15:0] divisor;
  } bsm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [LifeW-1:0] quot;
  } bsm_div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsm_divider.sv
`default_nettype none

module bsm_divider #(
  parameter int unsigned DvdW = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bsm_pkg::bsm_div_req_t req_i,
  input  wire logic [DvdW-1:0]       dividend_i,
  output      bsm_pkg::bsm_div_rsp_t rsp_o
);
  import bsm_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            zero_q, zero_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     dsr_q, dsr_d;

  logic [16:0] shifted;
  logic [17:0] diff;
  logic [31:0] quot_ext;

  // One quotient bit a cycle: the dividend shifts out at the top, quotient bits in at the bottom
  always_comb begin
    shifted = {rem_q, dvd_q[DvdW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      zero_d = (req_i.divisor == 16'd0);
      cnt_d  = CntW'(DvdW);
      dvd_d  = dividend_i;
      rem_d  = 16'd0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DvdW-2:0], ~diff[17]};
      rem_d = diff[17] ? shifted[15:0] : diff[15:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  // Saturate on a zero divisor or a quotient beyond the result width
  assign quot_ext = 32'(dvd_q);

  always_comb begin
    rsp_o.done = done_q;
    if (zero_q || (|quot_ext[31:LifeW])) begin
      rsp_o.quot = LIFE_MAX;
    end else begin
      rsp_o.quot = quot_ext[LifeW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/battery_status_monitor_unit.sv
// A transfer starts the divider; when it is done the quotient is registered, and the
// averaged result goes into the output register once that is free. The bit-serial restoring
// divider yields one quotient bit per cycle; the next reading is taken only after that load.
// A finished result waits in the output register while the next reading is taken.
// Reset (rst_ni low, asynchronous) clears the flags, the life average and the handshake
// state, and loads the configuration registers with their default values.
`default_nettype none

module battery_status_monitor_unit #(
  parameter int unsigned LIFE_FRAC_BITS = bsm_pkg::LifeFracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [bsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bsm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // reading stream
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // charge_level[6:0], voltage_mv[22:7], average_power_mw[38:23],
  // remaining_mah[54:39], average_current_ma[70:55], zero[71]
  input  wire logic [bsm_pkg::InTdataW-1:0]  s_axis_tdata,
  // level_valid[0]
  input  wire logic                          s_axis_tuser,
  // result stream
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // critical_low[0], low_battery_event[1], charging[2], charge_complete[3],
  // life_hours_q8[27:4], zero[31:28]
  output      logic [bsm_pkg::OutTdataW-1:0] m_axis_tdata
);
  import bsm_pkg::*;

  localparam int unsigned DvdW = 16 + LIFE_FRAC_BITS;

  // reading fields
  logic [6:0]  charge_level;
  logic [15:0] voltage_mv;
  logic [15:0] average_power_mw;
  logic [15:0] remaining_mah;
  logic [15:0] average_current_ma;

  assign charge_level       = s_axis_tdata[6:0];
  assign voltage_mv         = s_axis_tdata[22:7];
  assign average_power_mw   = s_axis_tdata[38:23];
  assign remaining_mah      = s_axis_tdata[54:39];
  assign average_current_ma = s_axis_tdata[70:55];

  // configuration
  logic [15:0] crit_volt_q;
  logic [6:0]  low_level_q;
  logic [6:0]  done_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_volt_q  <= CRIT_VOLT_RST;
      low_level_q  <= LOW_LEVEL_RST;
      done_level_q <= DONE_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CRIT_VOLT:  crit_volt_q  <= cfg_wdata_i;
        CFG_LOW_LEVEL:  low_level_q  <= cfg_wdata_i[6:0];
        CFG_DONE_LEVEL: done_level_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // control
  bsm_state_e state_q, state_d;
  logic       in_xfer;
  logic       out_load;
  logic       quot_load;

  bsm_div_req_t div_req;
  bsm_div_rsp_t div_rsp;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    quot_load     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_DIV:  quot_load = div_rsp.done;
      ST_OUT:  out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider
  always_comb begin
    div_req.start   = in_xfer;
    div_req.divisor = average_current_ma[15] ? 16'(-average_current_ma) : average_current_ma;
  end

  bsm_divider #(
    .DvdW(DvdW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i ({remaining_mah, {LIFE_FRAC_BITS{1'b0}}}),
    .rsp_o      (div_rsp)
  );

  // flag evaluation at transfer
  logic low_warned_q, low_warned_d;
  logic charging_q, charging_d;
  logic crit_q, crit_d;
  logic lowev_q, lowev_d;
  logic done_q, done_d;
  logic at_low;

  assign at_low = (charge_level <= low_level_q);

  always_comb begin
    low_warned_d = low_warned_q;
    charging_d   = charging_q;
    crit_d       = crit_q;
    lowev_d      = lowev_q;
    done_d       = done_q;
    if (in_xfer) begin
      crit_d  = 1'b0;
      lowev_d = 1'b0;
      done_d  = 1'b0;
      if (s_axis_tuser) begin
        crit_d       = (voltage_mv != 16'd0) && (voltage_mv <= crit_volt_q)
                       && average_power_mw[15];
        lowev_d      = at_low && !low_warned_q;
        low_warned_d = at_low;
        charging_d   = !average_power_mw[15];
        done_d       = (average_power_mw == 16'd0) && (charge_level == done_level_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_warned_q <= 1'b0;
      charging_q   <= 1'b0;
      crit_q       <= 1'b0;
      lowev_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      low_warned_q <= low_warned_d;
      charging_q   <= charging_d;
      crit_q       <= crit_d;
      lowev_q      <= lowev_d;
      done_q       <= done_d;
    end
  end

  // life average and output register
  logic [LifeW-1:0] quot_q;
  logic [LifeW-1:0] life_avg_q, life_avg_d;
  logic [LifeW:0]   life_sum;
  logic             m_valid_q, m_valid_d;
  logic [3:0]       m_flags_q;

  always_ff @(posedge clk_i) begin
    if (quot_load) begin
      quot_q <= div_rsp.quot;
    end
  end

  assign life_sum = {1'b0, life_avg_q} + {1'b0, quot_q};

  always_comb begin
    life_avg_d = life_avg_q;
    m_valid_d  = m_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      life_avg_d = life_sum[LifeW:1];
      m_valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_avg_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      life_avg_q <= life_avg_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // hold the flags of the transfer until its result is loaded
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_flags_q <= {done_q, charging_q, lowev_q, crit_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, life_avg_q, m_flags_q};

endmodule

`default_nettype wire

// File: hw/rtl/bsm_checker.sv
`default_nettype none

module bsm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one reading at a time: no back-to-back input transfers
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a reading is in progress");

  // charging done needs zero power, which also sets the charging flag
  a_done_charging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
    else $error("charge complete without charging flag");

  // critical low needs a discharging battery
  a_crit_discharging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[2])
    else $error("critical low while charging");

endmodule

bind battery_status_monitor_unit bsm_checker u_bsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: sim/battery_status_monitor_unit_tb.sv
`default_nettype none

module battery_status_monitor_unit_tb;
  import bsm_pkg::*;

  localparam int unsigned FracBits = LifeFracBitsDef;
  // index beyond the last register, must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned ItemsPerPhase = 206;

  typedef struct packed {
    logic        valid;
    logic [6:0]  level;
    logic [15:0] volt;
    logic [15:0] power;
    logic [15:0] rem;
    logic [15:0] cur;
  } reading_t;

  typedef struct packed {
    logic             crit;
    logic             lowev;
    logic             charging;
    logic             done;
    logic [LifeW-1:0] life;
  } status_t;

  typedef struct packed {
    reading_t rd;
    logic     typed;
    status_t  want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CFG_CRIT_VOLT;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  // predictor state and its copy of the registers
  logic [15:0]      crit_mv_q;
  logic [6:0]       low_pct_q;
  logic [6:0]       done_pct_q;
  logic             warned_q;
  logic             charging_q;
  logic [LifeW-1:0] life_avg_q;

  status_t     status_q[$];
  status_t     want_status;
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          gappy = 1'b1;

  battery_status_monitor_unit #(
    .LIFE_FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic status_t predict_status(reading_t r);
    status_t        s;
    logic [16:0]    mag;
    logic [40:0]    quot;
    logic [LifeW:0] sum;
    s = '0;
    if (r.valid) begin
      s.crit = (r.volt != 16'd0) && (r.volt <= crit_mv_q) && r.power[15];
      if (r.level <= low_pct_q) begin
        if (!warned_q) begin
          warned_q = 1'b1;
          s.lowev = 1'b1;
        end
      end else begin
        warned_q = 1'b0;
      end
      charging_q = !r.power[15];
      s.done = (r.power == 16'd0) && (r.level == done_pct_q);
    end
    s.charging = charging_q;
    mag = r.cur[15] ? 17'h10000 - {1'b0, r.cur} : {1'b0, r.cur};
    if (mag == 17'd0) begin
      quot = {17'd0, LIFE_MAX};
    end else begin
      quot = ({25'd0, r.rem} << FracBits) / {24'd0, mag};
    end
    if (quot > {17'd0, LIFE_MAX}) quot = {17'd0, LIFE_MAX};
    sum = {1'b0, life_avg_q} + {1'b0, quot[LifeW-1:0]};
    life_avg_q = sum[LifeW:1];
    s.life = life_avg_q;
    return s;
  endfunction

  // bias towards the thresholds so that events and their re-arm occur often
  function automatic reading_t rand_reading();
    reading_t r;
    r.valid = ($urandom_range(7) != 0);
    case ($urandom_range(7))
      0, 1: r.level = low_pct_q + 7'($urandom_range(4)) - 7'd2;
      2: r.level = done_pct_q;
      3: r.level = 7'($urandom_range(127));
      default: r.level = 7'($urandom_range(100));
    endcase
    case ($urandom_range(3))
      0: r.volt = crit_mv_q + 16'($urandom_range(2)) - 16'd1;
      1: r.volt = 16'($urandom_range(3));
      default: r.volt = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: r.power = 16'd0;
      1: r.power = 16'($urandom_range(6)) - 16'd3;
      default: r.power = 16'($urandom);
    endcase
    r.rem = ($urandom_range(7) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
    case ($urandom_range(4))
      0: r.cur = 16'd0;
      1: r.cur = $urandom_range(1) ? 16'h0001 : 16'hFFFF;
      2: r.cur = 16'($urandom_range(255)) - 16'd128;
      default: r.cur = 16'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < 100) begin
      $display("mismatch %s: got %0h, want %0h", what, got, want);
    end
    mismatch_cnt++;
  endtask

  task automatic add_row(logic v, logic [6:0] lvl, logic [15:0] volt, logic [15:0] pwr,
                         logic [15:0] rem, logic [15:0] cur, logic typed, status_t want);
    dir_row_t row;
    row.rd.valid = v;
    row.rd.level = lvl;
    row.rd.volt = volt;
    row.rd.power = pwr;
    row.rd.rem = rem;
    row.rd.cur = cur;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CRIT_VOLT: crit_mv_q = data;
      CFG_LOW_LEVEL: low_pct_q = data[6:0];
      CFG_DONE_LEVEL: done_pct_q = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] crit, logic [15:0] low, logic [15:0] done);
    write_reg(CFG_CRIT_VOLT, crit);
    write_reg(CFG_LOW_LEVEL, low);
    write_reg(CFG_DONE_LEVEL, done);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_reading(reading_t r, logic typed, status_t fixed);
    status_t s;
    if (burst_left == 0) begin
      if (gappy) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.valid;
    s_axis_tdata <= {1'b0, r.cur, r.rem, r.power, r.volt, r.level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // advance the predictor even where the row carries its own expectation
    s = predict_status(r);
    status_q.push_back(typed ? fixed : s);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // receiver: rotating ready pattern, with long hold-offs to back the block up
  initial begin : rx_side
    int unsigned rx_cnt;
    int unsigned next_hold;
    int unsigned pos;
    logic [31:0] pat;
    rx_cnt = 0;
    next_hold = 200;
    pos = 0;
    pat = '1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) rx_cnt++;
      if (rx_cnt >= next_hold) begin
        next_hold += 700;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        if (pos % 500 == 0) begin
          pat = ($urandom_range(3) == 0) ? '1 : ($urandom | 32'h1);
        end
        m_axis_tready <= pat[pos % 32];
        pos++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want_status = status_q.pop_front();
        if (m_axis_tdata[0] !== want_status.crit)
          report_mismatch("critical_low", m_axis_tdata[0], want_status.crit);
        if (m_axis_tdata[1] !== want_status.lowev)
          report_mismatch("low_battery_event", m_axis_tdata[1], want_status.lowev);
        if (m_axis_tdata[2] !== want_status.charging)
          report_mismatch("charging", m_axis_tdata[2], want_status.charging);
        if (m_axis_tdata[3] !== want_status.done)
          report_mismatch("charge_complete", m_axis_tdata[3], want_status.done);
        if (m_axis_tdata[27:4] !== want_status.life)
          report_mismatch("life_hours_q8", m_axis_tdata[27:4], want_status.life);
      end
    end
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    crit_mv_q = CRIT_VOLT_RST;
    low_pct_q = LOW_LEVEL_RST;
    done_pct_q = DONE_LEVEL_RST;
    warned_q = 1'b0;
    charging_q = 1'b0;
    life_avg_q = '0;

    // zero current saturates; from reset the average is half the maximum
    add_row(1, 7'd50, 16'd4000, 16'd100, 16'd0, 16'd0, 1,
            status_t'({1'b0, 1'b0, 1'b1, 1'b0, 24'h7FFFFF}));
    // critical and first fall below the low threshold
    add_row(1, 7'd10, 16'd3000, -16'sd500, 16'd100, -16'sd100, 1,
            status_t'({1'b1, 1'b1, 1'b0, 1'b0, 24'h40007F}));
    add_row(1, 7'd5, 16'd3000, -16'sd500, 16'd100, -16'sd100, 0, '0);
    // invalid level keeps the flags
    add_row(0, 7'd0, 16'd1, -16'sd1, 16'd50, 16'd7, 0, '0);
    // zero voltage, re-arm above the threshold
    add_row(1, 7'd21, 16'd0, -16'sd1, 16'd1000, 16'd3, 0, '0);
    add_row(1, 7'd20, 16'd3400, -16'sd1, 16'd1000, 16'd3, 0, '0);
    add_row(1, 7'd20, 16'd3401, -16'sd1, 16'd999, -16'sd3, 0, '0);
    // charging done at the done level with zero power
    add_row(1, 7'd1, 16'd4000, 16'd0, 16'd500, 16'd10, 0, '0);
    add_row(1, 7'd42, 16'd4000, 16'd0, 16'd500, 16'd10, 0, '0);
    add_row(1, 7'd100, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 0, '0);
    add_row(1, 7'd127, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000, 0, '0);
    add_row(1, 7'd64, 16'd1, 16'h8000, 16'hFFFF, 16'd1, 0, '0);
    add_row(1, 7'd0, 16'd1, 16'd1, 16'd0, 16'hFFFF, 0, '0);
    add_row(0, 7'd127, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 0, '0);
    add_row(1, 7'd0, 16'd2, -16'sd2, 16'd12345, 16'd0, 0, '0);
    add_row(1, 7'd1, 16'd3399, 16'd0, 16'd1, 16'hFFFF, 0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_reading(dir_rows[i].rd, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: set_config(16'($urandom), 16'($urandom_range(100)), 16'($urandom_range(100)));
        1: set_config(16'd0, 16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'd100, 16'd100);
        // upper data bits fall outside the level registers
        3: set_config(16'h8000, 16'hFFFF, 16'hFF80);
        4: begin
          write_reg(CfgIdxSpare, 16'($urandom));
          set_config(16'($urandom), 16'($urandom_range(100)), 16'($urandom_range(100)));
        end
        5: set_config(CRIT_VOLT_RST, {9'd0, LOW_LEVEL_RST}, {9'd0, DONE_LEVEL_RST});
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      gappy = (p % 3 != 1);
      repeat (ItemsPerPhase) send_reading(rand_reading(), 1'b0, '0);
    end

    wait_drained();
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
